[sv/circle_column_span_raster_defines.svh]
// Assertion macros used by the top-level file of this block.
`ifndef CIRCLE_COLUMN_SPAN_RASTER_DEFINES_SVH
`define CIRCLE_COLUMN_SPAN_RASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CCSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("span raster check failed");
`define CCSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("span raster check failed");
`else
`define CCSR_ASSERT_SAME(label, ante, cons)
`define CCSR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/ccsr_pkg.sv]
package ccsr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int OUT_BITS    = 14;

  localparam int DX_W   = RADIUS_BITS + 1;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int REM_W  = RADIUS_BITS + 3;
  localparam int SUM_W  = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int WIDE_W = SUM_W + OUT_BITS;
  localparam int CNT_W  = $clog2(RADIUS_BITS);
  localparam int CFG_W  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_RADIUS,
    CFG_FILL_MODE
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_R,
    ST_SQ_D,
    ST_ROOT,
    ST_OUT_A,
    ST_OUT_B
  } seq_state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
    logic                   fill_mode;
  } ccsr_cfg_t;

  typedef struct packed {
    logic                   done;
    logic [RADIUS_BITS-1:0] root;
    logic [REM_W-1:0]       rem;
  } isq_rsp_t;

endpackage

[sv/ccsr_if.sv]
interface ccsr_in_if import ccsr_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ccsr_out_if import ccsr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] column_x;
  logic signed [OUT_BITS-1:0] span_low_y;
  logic signed [OUT_BITS-1:0] span_high_y;
  logic                       last_of_run;
  logic                       final_column;

  modport source (output valid, output column_x, output span_low_y, output span_high_y,
                  output last_of_run, output final_column, input ready);
  modport sink (input valid, input column_x, input span_low_y, input span_high_y,
                input last_of_run, input final_column, output ready);
endinterface

[sv/ccsr_isqrt.sv]
module ccsr_isqrt import ccsr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output isq_rsp_t        rsp
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RADIUS_BITS - 1);

  logic [SQ_W-1:0]        src_r;
  logic [REM_W-1:0]       rem_r;
  logic [RADIUS_BITS-1:0] root_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // One result bit per step: bring down two radicand bits and try root*4+1.
  assign rem_sh = {rem_r[REM_W-3:0], src_r[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      src_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      src_r  <= src_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RADIUS_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        busy_r <= (cnt_r != LAST_STEP);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;
  assign rsp.rem  = rem_r;

endmodule

[sv/ccsr_seq.sv]
module ccsr_seq import ccsr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  ccsr_cfg_t       cfg,
  ccsr_in_if.sink         in_ch,
  ccsr_out_if.source      out_ch,
  output logic            root_start,
  output logic [SQ_W-1:0] radicand,
  input  isq_rsp_t        rsp
);

  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [SUM_W-1:0] v);
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[OUT_BITS-1:0];
  endfunction

  seq_state_t state_r, state_nxt;

  logic signed [DX_W-1:0]  dx_r;
  logic                    active_r;
  logic signed [SUM_W-1:0] prev_up_r;
  logic signed [SUM_W-1:0] prev_low_r;
  logic signed [SUM_W-1:0] up_r;
  logic signed [SUM_W-1:0] low_r;
  logic [SQ_W-1:0]         rr_r;

  logic [OUT_BITS-1:0] out_x_r;
  logic [OUT_BITS-1:0] out_lo_r;
  logic [OUT_BITS-1:0] out_hi_r;
  logic                out_last_r;
  logic                out_fin_r;

  logic                    in_take;
  logic                    out_take;
  logic                    mul_dx;
  logic [RADIUS_BITS-1:0]  dx_abs;
  logic [RADIUS_BITS-1:0]  mul_a;
  logic [SQ_W-1:0]         prod;
  logic signed [DX_W-1:0]  radius_s;
  logic [RADIUS_BITS:0]    h;
  logic signed [SUM_W-1:0] cy_s;
  logic signed [SUM_W-1:0] up_w;
  logic signed [SUM_W-1:0] low_w;
  logic signed [SUM_W-1:0] x_w;
  logic                    fin_w;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;

  // Shared multiplier squares the radius first, then the column offset.
  assign radius_s = $signed({1'b0, cfg.radius});
  assign dx_abs   = dx_r[DX_W-1] ? RADIUS_BITS'(-dx_r) : RADIUS_BITS'(dx_r);
  assign mul_a    = mul_dx ? dx_abs : cfg.radius;
  assign prod     = SQ_W'(mul_a * mul_a);
  assign radicand = (prod > rr_r) ? '0 : (rr_r - prod);

  // The root rounds up when the remainder exceeds the floor root.
  assign h     = (rsp.rem > REM_W'(rsp.root)) ? ((RADIUS_BITS + 1)'(rsp.root) + 1'b1)
                                              : (RADIUS_BITS + 1)'(rsp.root);
  assign cy_s  = $signed(SUM_W'(cfg.center_y));
  assign up_w  = cy_s + $signed(SUM_W'(h));
  assign low_w = cy_s - $signed(SUM_W'(h));
  assign x_w   = $signed(SUM_W'(cfg.center_x)) + SUM_W'(dx_r);
  assign fin_w = (dx_r >= radius_s);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid && (in_ch.restart || active_r)) state_nxt = ST_SQ_R;
      ST_SQ_R:  state_nxt = ST_SQ_D;
      ST_SQ_D:  state_nxt = ST_ROOT;
      ST_ROOT:  if (rsp.done) state_nxt = ST_OUT_A;
      ST_OUT_A: if (out_ch.ready) state_nxt = out_last_r ? ST_IDLE : ST_OUT_B;
      ST_OUT_B: if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    mul_dx       = 1'b0;
    root_start   = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SQ_D: begin
        mul_dx     = 1'b1;
        root_start = 1'b1;
      end
      ST_OUT_A: out_ch.valid = 1'b1;
      ST_OUT_B: out_ch.valid = 1'b1;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dx_r       <= '0;
      active_r   <= 1'b0;
      prev_up_r  <= '0;
      prev_low_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        if (in_ch.restart) begin
          active_r   <= 1'b1;
          dx_r       <= -radius_s;
          prev_up_r  <= cy_s;
          prev_low_r <= cy_s;
        end else if (active_r) begin
          dx_r <= dx_r + 1'b1;
        end
      end
      if ((state_r == ST_ROOT) && rsp.done && fin_w) begin
        active_r <= 1'b0;
      end
      if (out_take && out_last_r) begin
        prev_up_r  <= up_r;
        prev_low_r <= low_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SQ_R) begin
      rr_r <= prod;
    end
    if ((state_r == ST_ROOT) && rsp.done) begin
      up_r      <= up_w;
      low_r     <= low_w;
      out_x_r   <= to_out(x_w);
      out_fin_r <= fin_w;
      if (cfg.fill_mode) begin
        out_lo_r   <= to_out(low_w);
        out_hi_r   <= to_out(up_w);
        out_last_r <= 1'b1;
      end else begin
        out_lo_r   <= to_out((up_w < prev_up_r) ? up_w : prev_up_r);
        out_hi_r   <= to_out((up_w < prev_up_r) ? prev_up_r : up_w);
        out_last_r <= 1'b0;
      end
    end else if ((state_r == ST_OUT_A) && out_take && !out_last_r) begin
      out_lo_r   <= to_out((low_r < prev_low_r) ? low_r : prev_low_r);
      out_hi_r   <= to_out((low_r < prev_low_r) ? prev_low_r : low_r);
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.column_x     = out_x_r;
  assign out_ch.span_low_y   = out_lo_r;
  assign out_ch.span_high_y  = out_hi_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.final_column = out_fin_r;

endmodule

[sv/circle_column_span_raster.sv]
// The first span of a column is valid once its item has passed ST_SQ_R, ST_SQ_D and ST_ROOT
// and the root unit's 11 iterations have finished. A new item is accepted only in ST_IDLE,
// after the spans of the column before it have been taken.
// An advance with no circle in progress is accepted, gives no span, and ready stays high.
// Reset is synchronous and active low; it clears the configuration registers and the circle state.
`include "circle_column_span_raster_defines.svh"

module circle_column_span_raster import ccsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  ccsr_in_if.sink              in_ch,
  ccsr_out_if.source           out_ch
);

  ccsr_cfg_t       cfg_r;
  logic            root_start;
  logic [SQ_W-1:0] radicand;
  isq_rsp_t        rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:  cfg_r.center_x  <= cfg_wdata[COORD_BITS-1:0];
        CFG_CENTER_Y:  cfg_r.center_y  <= cfg_wdata[COORD_BITS-1:0];
        CFG_RADIUS:    cfg_r.radius    <= cfg_wdata[RADIUS_BITS-1:0];
        CFG_FILL_MODE: cfg_r.fill_mode <= cfg_wdata[0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  ccsr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .root_start (root_start),
    .radicand   (radicand),
    .rsp        (rsp)
  );

  ccsr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .rsp      (rsp)
  );

  `CCSR_ASSERT_NEXT(a_accept_no_out, in_ch.valid && in_ch.ready, !out_ch.valid)
  `CCSR_ASSERT_SAME(a_busy_while_out, out_ch.valid, !in_ch.ready)
  `CCSR_ASSERT_NEXT(a_last_to_idle, out_ch.valid && out_ch.ready && out_ch.last_of_run,
                    in_ch.ready)
  `CCSR_ASSERT_NEXT(a_upper_then_lower, out_ch.valid && out_ch.ready && !out_ch.last_of_run,
                    out_ch.valid && out_ch.last_of_run)

endmodule

[tb/sv/tb.sv]
module tb import ccsr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [OUT_BITS-1:0] column_x;
    logic [OUT_BITS-1:0] span_low_y;
    logic [OUT_BITS-1:0] span_high_y;
    logic                last_of_run;
    logic                final_column;
  } span_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  ccsr_in_if  in_if ();
  ccsr_out_if out_if ();

  circle_column_span_raster dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  ccsr_cfg_t              raster_cfg;
  logic                   circle_on;
  logic signed [DX_W-1:0] col_off;
  logic signed [OUT_BITS-1:0] prev_upper;
  logic signed [OUT_BITS-1:0] prev_lower;

  span_t expected_spans[$];
  logic  pending_restarts[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int spans_checked = 0;
  int columns_drawn = 0;
  int circles_closed = 0;
  int fill_columns = 0;
  int largest_radius = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_span(int x, int a, int b, logic last, logic fin);
    span_t sp;
    sp.column_x     = OUT_BITS'(x);
    sp.span_low_y   = OUT_BITS'((a < b) ? a : b);
    sp.span_high_y  = OUT_BITS'((a < b) ? b : a);
    sp.last_of_run  = last;
    sp.final_column = fin;
    expected_spans.push_back(sp);
  endfunction

  function automatic void draw_column(logic restart);
    longint r2, dd, v, s, t, h;
    int     r, dx, x, up, low;
    logic   fin;
    r = int'(raster_cfg.radius);
    if (restart) begin
      circle_on  = 1'b1;
      col_off    = -DX_W'(r);
      prev_upper = OUT_BITS'(raster_cfg.center_y);
      prev_lower = OUT_BITS'(raster_cfg.center_y);
    end else begin
      if (!circle_on) return;
      col_off = col_off + DX_W'(1);
    end
    dx = int'(col_off);
    r2 = longint'(r) * r;
    dd = longint'(dx) * dx;
    v  = (dd > r2) ? 0 : r2 - dd;
    s  = 0;
    for (int b = RADIUS_BITS; b >= 0; b--) begin
      t = s + (longint'(1) << b);
      if (t * t <= v) s = t;
    end
    h   = (v - s * s > s) ? s + 1 : s;
    x   = int'(raster_cfg.center_x) + dx;
    up  = int'(raster_cfg.center_y) + int'(h);
    low = int'(raster_cfg.center_y) - int'(h);
    fin = (dx >= r);
    if (fin) begin
      circle_on = 1'b0;
      circles_closed++;
    end
    columns_drawn++;
    if (raster_cfg.fill_mode) begin
      add_span(x, low, up, 1'b1, fin);
      fill_columns++;
    end else begin
      add_span(x, up, int'(prev_upper), 1'b0, fin);
      add_span(x, low, int'(prev_lower), 1'b1, fin);
    end
    prev_upper = OUT_BITS'(up);
    prev_lower = OUT_BITS'(low);
  endfunction

  task automatic write_reg(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      CFG_CENTER_X:  raster_cfg.center_x = COORD_BITS'(value);
      CFG_CENTER_Y:  raster_cfg.center_y = COORD_BITS'(value);
      CFG_RADIUS:    raster_cfg.radius = RADIUS_BITS'(value);
      CFG_FILL_MODE: raster_cfg.fill_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_circle(int cx, int cy, int r, int fill);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_FILL_MODE, fill);
    if (r > largest_radius) largest_radius = r;
    @(negedge clk);
  endtask

  task automatic queue_advances(int n);
    repeat (n) pending_restarts.push_back(1'b0);
  endtask

  task automatic queue_circle(int advances);
    pending_restarts.push_back(1'b1);
    queue_advances(advances);
  endtask

  // An advance with no circle in progress gives no span; a quiet tail of SETTLE_CYCLES follows every drain.
  task automatic settle();
    do @(negedge clk);
    while (pending_restarts.size() != 0 || in_if.valid || expected_spans.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) draw_column(in_if.restart);
      if (!in_if.valid || in_if.ready) begin
        if (pending_restarts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.restart <= pending_restarts.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : span_check
    span_t got;
    span_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.column_x     = out_if.column_x;
        got.span_low_y   = out_if.span_low_y;
        got.span_high_y  = out_if.span_high_y;
        got.last_of_run  = out_if.last_of_run;
        got.final_column = out_if.final_column;
        spans_checked++;
        if (expected_spans.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Unexpected span: x %0d y %0d..%0d last %0b final %0b",
                     $signed(got.column_x), $signed(got.span_low_y),
                     $signed(got.span_high_y), got.last_of_run, got.final_column);
        end else begin
          want = expected_spans.pop_front();
          if (got.column_x !== want.column_x || got.span_low_y !== want.span_low_y ||
              got.span_high_y !== want.span_high_y || got.last_of_run !== want.last_of_run ||
              got.final_column !== want.final_column) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Span mismatch: expected x %0d y %0d..%0d last %0b final %0b",
                       $signed(want.column_x), $signed(want.span_low_y),
                       $signed(want.span_high_y), want.last_of_run, want.final_column);
              $display("               got x %0d y %0d..%0d last %0b final %0b",
                       $signed(got.column_x), $signed(got.span_low_y),
                       $signed(got.span_high_y), got.last_of_run, got.final_column);
            end
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int target;
    int r_now;
    int pick;
    int n_adv;
    int cx;
    int cy;
    int r_new;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    raster_cfg    = '0;
    circle_on     = 1'b0;
    col_off       = '0;
    prev_upper    = '0;
    prev_lower    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still hold their reset values: origin, radius zero, outline.
    queue_advances(1);
    queue_circle(0);
    queue_advances(1);
    settle();
    set_circle(4095, 4095, 3, 0);
    queue_circle(6);
    queue_advances(1);
    settle();
    set_circle(0, 0, 2, 1);
    queue_circle(4);
    settle();
    // The radius shrinks and the mode flips while a circle is half drawn.
    set_circle(100, 50, 5, 0);
    queue_circle(2);
    settle();
    set_circle(100, 50, 1, 1);
    queue_advances(4);
    settle();
    set_circle(2047, 2047, 2047, 0);
    queue_circle(2);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      target = columns_drawn + ITEMS_PER_PHASE;
      while (columns_drawn < target) begin
        if ($urandom_range(1)) begin
          case ($urandom_range(9))
            0:       r_new = ($urandom_range(1)) ? 2047 : $urandom_range(41, 2047);
            1, 2:    r_new = $urandom_range(9, 40);
            default: r_new = $urandom_range(0, 8);
          endcase
          case ($urandom_range(9))
            0:       cx = 0;
            1:       cx = 4095;
            default: cx = $urandom_range(0, 4095);
          endcase
          case ($urandom_range(9))
            0:       cy = 0;
            1:       cy = 4095;
            default: cy = $urandom_range(0, 4095);
          endcase
          set_circle(cx, cy, r_new, $urandom_range(1));
        end
        r_now = int'(raster_cfg.radius);
        repeat ($urandom_range(1, 3)) begin
          pick = $urandom_range(19);
          if (pick < 2) begin
            queue_advances($urandom_range(1, 3));
          end else if (pick < 6 && circle_on) begin
            queue_advances($urandom_range(1, (r_now < 10) ? 2 * r_now + 1 : 20));
          end else begin
            if (r_now > 30) n_adv = $urandom_range(0, 12);
            else if (pick < 9) n_adv = $urandom_range(0, 2 * r_now);
            else n_adv = 2 * r_now + $urandom_range(0, 1);
            queue_circle(n_adv);
          end
        end
        settle();
      end
    end

    $display("Checked %0d spans from %0d columns (%0d in fill mode), %0d circles closed.",
             spans_checked, columns_drawn, fill_columns, circles_closed);
    $display("Radii reached %0d, with sender gaps and receiver stalls in separate phases.",
             largest_radius);
    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
